@@ hw/rtl/kerl_pkg.sv @@
// Package with the table size, operation codes and transaction types of the rate limiter.
package kerl_pkg;

  localparam int unsigned TableEntries = 16;

  localparam logic OpTrigger = 1'b0;
  localparam logic OpReset   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] event_id;
    logic [30:0] interval_ms;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic fired;
    logic table_full;
    logic known;
  } out_item_t;

endpackage

@@ hw/rtl/keyed_event_rate_limiter.sv @@
// Keyed event rate limiter: associative table of event identifiers and last firing times.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid_i / in_stall_o   kerl_pkg::in_item_t   in_item_i
//   out       source     out_valid_o / out_stall_i kerl_pkg::out_item_t  out_item_o
//
// A transaction accepted at a clock edge is held in the input register; the table lookup and
// update run combinationally from that register and load the result register once it can take
// a new result, and the result is then offered from the result register.
// A new transaction can be accepted every cycle while the output does not stall; the rate is
// set by the lookup, which compares the identifier against all table entries at once.
// Reset clears the entry valid bits only; identifiers and times are never read unless valid.
// A stall on the output holds the result register, and the input register then fills and
// the input stalls until the result is taken.
module keyed_event_rate_limiter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kerl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kerl_pkg::out_item_t out_item_o
);

  localparam int unsigned N = kerl_pkg::TableEntries;

  // Input register.
  logic               s1_valid_q, s1_valid_d;
  kerl_pkg::in_item_t s1_item_q;

  // Result register.
  logic                out_valid_q, out_valid_d;
  kerl_pkg::out_item_t out_item_q, out_item_d;

  // Table storage. Only the valid bits are reset.
  logic [N-1:0]  used_q, used_d;
  logic [31:0]   ids_q   [N];
  logic [31:0]   times_q [N];

  logic          out_adv;
  logic          process;
  logic          in_accept;

  logic [N-1:0]  match_vec;
  logic [N-1:0]  free_vec;
  logic [N-1:0]  free_first;
  logic [N-1:0]  sel_vec;
  logic          hit;
  logic          has_free;
  logic [31:0]   sel_time;
  logic [31:0]   elapsed;
  logic          is_trigger;
  logic          insert;
  logic          fire;
  logic          write_time;
  logic [31:0]   new_time;

  // The result register can take a new result when it is empty or being drained.
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign process    = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !out_adv);
  assign out_valid_d = process || (out_valid_q && out_stall_i);

  // Parallel identifier compare across the whole table.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      match_vec[k] = used_q[k] && (ids_q[k] == s1_item_q.event_id);
    end
  end

  // Lowest free slot as a one-hot vector.
  assign free_vec   = ~used_q;
  assign free_first = free_vec & (~free_vec + {{(N-1){1'b0}}, 1'b1});
  assign hit        = |match_vec;
  assign has_free   = |free_vec;

  assign is_trigger = (s1_item_q.operation == kerl_pkg::OpTrigger);
  assign insert     = is_trigger && !hit && has_free;

  // Identifiers are unique in the table, so at most one match bit is set.
  assign sel_vec = hit ? match_vec : free_first;

  // A newly inserted entry starts with a last time of zero.
  always_comb begin
    sel_time = '0;
    for (int k = 0; k < N; k++) begin
      sel_time = sel_time | ({32{match_vec[k]}} & times_q[k]);
    end
  end

  // Wrapping difference against the interval, which is always below 2^31.
  assign elapsed = s1_item_q.now_ms - sel_time;
  assign fire    = is_trigger && (hit || has_free) &&
                   (elapsed > {1'b0, s1_item_q.interval_ms});

  // A reset of a known entry or a firing trigger moves the time to now.
  assign write_time = fire || (!is_trigger && hit);
  assign new_time   = fire || !is_trigger ? s1_item_q.now_ms : 32'd0;

  always_comb begin
    used_d = used_q;
    if (process && insert) begin
      used_d = used_q | free_first;
    end
  end

  always_comb begin
    out_item_d            = out_item_q;
    if (process) begin
      out_item_d.fired      = fire;
      out_item_d.table_full = is_trigger && !hit && !has_free;
      out_item_d.known      = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    out_item_q <= out_item_d;
  end

  // Table entry writes, one-hot on the selected slot.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (process && sel_vec[k]) begin
        if (insert) begin
          ids_q[k] <= s1_item_q.event_id;
        end
        if (insert || write_time) begin
          times_q[k] <= new_time;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hw/rtl/kerl_checker.sv @@
// Port-level checker for the keyed event rate limiter and its bind statement.
module kerl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input kerl_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input kerl_pkg::out_item_t out_item_o
);

  // A result never both fires and reports a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.fired && out_item_o.table_full))
    else $error("fired and table_full both set");

  // A refused identifier cannot also be known.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.table_full |-> !out_item_o.known)
    else $error("table_full with known set");

  // The input only stalls behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // A stalled input transaction is held by the sender.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input transaction changed");

endmodule

bind keyed_event_rate_limiter kerl_checker u_kerl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ tb/keyed_event_rate_limiter_tb.sv @@
// Self-checking testbench for the keyed event rate limiter with a clocked driver and monitor.
module keyed_event_rate_limiter_tb;
  import kerl_pkg::*;

  localparam int NumRandom  = 1500;
  localparam int PoolSize   = 20;
  localparam int PhaseLen   = 510;
  localparam int VerdictCap = 4096;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } queued_event_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  keyed_event_rate_limiter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the identifier table kept by the predictor.
  logic [31:0] shadow_ids   [TableEntries];
  logic [31:0] shadow_times [TableEntries];
  bit          shadow_used  [TableEntries];

  queued_event_t trigger_queue[$];
  out_item_t     verdicts [VerdictCap];
  int            issued_cnt  = 0;
  int            verdict_cnt = 0;
  int            err_cnt     = 0;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;

  // Sender idles lightly and receiver heavily first, then the reverse, then neither idles.
  always_comb begin
    if (issued_cnt < PhaseLen) begin
      send_idle_pct = 26;
      recv_idle_pct = 55;
    end else if (issued_cnt < 2 * PhaseLen) begin
      send_idle_pct = 55;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Looks up the identifier, inserts or refuses it, and decides whether the event fires.
  function automatic out_item_t limiter_predict(in_item_t it);
    out_item_t   res;
    int          slot;
    logic [31:0] gap;
    res  = '0;
    slot = -1;
    for (int k = 0; k < TableEntries; k++) begin
      if (slot < 0 && shadow_used[k] && shadow_ids[k] == it.event_id) slot = k;
    end
    if (it.operation == OpReset) begin
      if (slot >= 0) begin
        shadow_times[slot] = it.now_ms;
        res.known = 1'b1;
      end
    end else begin
      if (slot >= 0) begin
        res.known = 1'b1;
      end else begin
        for (int k = 0; k < TableEntries; k++) begin
          if (slot < 0 && !shadow_used[k]) slot = k;
        end
        if (slot >= 0) begin
          shadow_used[slot]  = 1'b1;
          shadow_ids[slot]   = it.event_id;
          shadow_times[slot] = '0;
        end else begin
          res.table_full = 1'b1;
        end
      end
      if (slot >= 0) begin
        gap = it.now_ms - shadow_times[slot];
        if (gap > {1'b0, it.interval_ms}) begin
          shadow_times[slot] = it.now_ms;
          res.fired = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic queue_event(input logic op, input logic [31:0] id, input logic [30:0] intv,
                             input logic [31:0] now, input bit drain_first);
    queued_event_t qe;
    qe.item.operation   = op;
    qe.item.event_id    = id;
    qe.item.interval_ms = intv;
    qe.item.now_ms      = now;
    qe.drain_first      = drain_first;
    trigger_queue.push_back(qe);
  endtask

  task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch at result %0d (%s): ", verdict_cnt, what,
               "expected fired=%0b full=%0b known=%0b, ",
               want.fired, want.table_full, want.known,
               "got fired=%0b full=%0b known=%0b",
               got.fired, got.table_full, got.known);
    end
  endtask

  // Driver: predicts each accepted transaction and presents the next queued one.
  always @(posedge clk_i or negedge rst_ni) begin
    logic took;
    bit   pause;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      issued_cnt <= 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        verdicts[issued_cnt] = limiter_predict(in_item_i);
        issued_cnt <= issued_cnt + 1;
      end
      if (!in_valid_i || took) begin
        pause = ($urandom_range(0, 99) < send_idle_pct);
        // A marked transaction waits until every earlier result has been taken.
        if (trigger_queue.size() != 0 && trigger_queue[0].drain_first &&
            (took || issued_cnt != verdict_cnt)) begin
          pause = 1'b1;
        end
        if (trigger_queue.size() != 0 && !pause) begin
          in_item_i  <= trigger_queue[0].item;
          in_valid_i <= 1'b1;
          void'(trigger_queue.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest outstanding verdict.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      verdict_cnt <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_cnt >= issued_cnt) begin
          note_mismatch("no result outstanding", '0, out_item_o);
        end else begin
          want = verdicts[verdict_cnt];
          if (out_item_o.fired !== want.fired || out_item_o.table_full !== want.table_full ||
              out_item_o.known !== want.known) begin
            note_mismatch("field differs", want, out_item_o);
          end
          verdict_cnt <= verdict_cnt + 1;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    logic [31:0] pool [PoolSize];
    logic [31:0] cur_now;
    logic [31:0] id;
    logic [31:0] now;
    logic [30:0] intv;
    logic        op;
    bit          dup;
    int unsigned r;

    // Identifier pool: the first sixteen fill the table, the rest are always refused.
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < PoolSize; k++) begin
      do begin
        id  = $urandom;
        dup = 1'b0;
        for (int j = 0; j < k; j++) if (pool[j] == id) dup = 1'b1;
      end while (dup);
      pool[k] = id;
    end

    // Directed part.
    queue_event(OpReset,   pool[0], 31'h0,        32'h0,         1'b0); // reset of unknown id
    queue_event(OpTrigger, pool[0], 31'h0,        32'h0,         1'b0); // insert, no fire
    queue_event(OpTrigger, pool[0], 31'h0,        32'h1,         1'b0); // fires
    queue_event(OpTrigger, pool[0], 31'h7FFFFFFF, 32'hFFFFFFFF,  1'b0); // largest interval
    queue_event(OpReset,   pool[0], 31'h7FFFFFFF, 32'hFFFFFFF0,  1'b0); // reset of known id
    queue_event(OpTrigger, pool[0], 31'h20,       32'h10,        1'b0); // wrap, equal gap
    queue_event(OpTrigger, pool[0], 31'h20,       32'h11,        1'b0); // wrap, fires
    queue_event(OpTrigger, pool[1], 31'h7FFFFFFF, 32'h80000000,  1'b0); // insert and fire
    queue_event(OpTrigger, pool[1], 31'h0,        32'h80000000,  1'b0); // zero gap
    for (int k = 2; k < TableEntries; k++) begin
      queue_event(OpTrigger, pool[k], 31'($urandom_range(0, 100)), $urandom, 1'b0);
    end
    queue_event(OpTrigger, pool[16], 31'h0, 32'hFFFFFFFF, 1'b0); // table full
    queue_event(OpReset,   pool[17], 31'h0, 32'h0,        1'b0); // unknown reset when full

    // Random part: mostly pooled identifiers on a slowly advancing clock.
    cur_now = $urandom;
    for (int i = 0; i < NumRandom; i++) begin
      op = ($urandom_range(0, 99) < 20) ? OpReset : OpTrigger;
      id = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, PoolSize - 1)] : $urandom;
      cur_now = cur_now + $urandom_range(0, 40);
      if ($urandom_range(0, 99) < 4) cur_now = $urandom;
      now = ($urandom_range(0, 99) < 5) ? $urandom : cur_now;
      r = $urandom_range(0, 99);
      if (r < 70)      intv = 31'($urandom_range(0, 60));
      else if (r < 85) intv = 31'($urandom);
      else if (r < 92) intv = '0;
      else             intv = 31'h7FFFFFFF;
      queue_event(op, id, intv, now, (i == 0 || i == 500 || i == 1000));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (trigger_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (verdict_cnt != issued_cnt) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && verdict_cnt == issued_cnt) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d of %0d results taken", verdict_cnt, issued_cnt);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/kerl_pkg.sv
hw/rtl/keyed_event_rate_limiter.sv
hw/rtl/kerl_checker.sv
tb/keyed_event_rate_limiter_tb.sv
